FILE: hdl/frn_pkg.sv
// Package for the Fresnel refraction unit: beat payload types, pipeline side data
// and fixed-point constants. Used by the top level and the testbench.
`timescale 1ns / 1ps
package frn_pkg;

  localparam int ONE_Q14 = 16384;
  localparam logic [14:0] ENV_IOR_RESET = 15'd8192;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        surface_ior;
  } frn_in_t;

  typedef struct packed {
    logic [14:0]        reflectance;
    logic signed [15:0] refr_x;
    logic signed [15:0] refr_y;
    logic signed [15:0] refr_z;
    logic               total_reflect;
  } frn_out_t;

  typedef struct packed {
    logic             tir;
    logic [14:0]      etai;
    logic [14:0]      etat;
    logic [14:0]      ac;
    logic [2:0][16:0] nn;
    logic [2:0][46:0] w;
  } side_t;

  typedef struct packed {
    logic             tir;
    logic [2:0][15:0] refr;
  } vec_t;

endpackage

FILE: hdl/frn_chan_if.sv
// Valid/ready channel interface carrying one beat of payload type T.
// Depends on nothing; instantiated with the payload types of frn_pkg.
`timescale 1ns / 1ps
interface frn_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/fresnel_refraction_unit.sv
// Top level of the Fresnel refraction unit: a fully pipelined datapath.
// Depends on frn_pkg and frn_chan_if.
`timescale 1ns / 1ps
// The ray channel takes one beat per hit: unit direction, unit normal and the
// surface index. The result channel gives one beat per ray: reflectance, the
// unnormalized refraction vector and the total reflection flag. The index of
// the surrounding medium is written through cfg_we and cfg_wdata; the user must write it while idle (not enforced).
// The datapath is 84 register stages deep. A new ray is taken in every cycle
// unless the pipeline is stalled; the depth is set by the bit-per-stage dividers
// (29 stages for cos t squared, 31 for the Fresnel ratios) and the 15-stage
// square root between them.
// All stages move together: when the output register holds a beat that the
// receiver does not take, the whole pipeline holds and ray.ready is low.
// Synchronous reset empties the pipeline and sets the surrounding index to 1.0.
module fresnel_refraction_unit (
  input  logic        clk,
  input  logic        rst,
  frn_chan_if.sink    ray,
  frn_chan_if.source  result,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam int D1_N = 29;
  localparam int SQ_N = 15;
  localparam int FD_N = 31;
  localparam int VD_N = 15;
  localparam int PIPE_DEPTH = 4 + (D1_N + 1) + SQ_N + 2 + FD_N + 2;
  localparam int VDL_N = PIPE_DEPTH - (4 + (D1_N + 1) + SQ_N + 2 + 2 + VD_N);
  localparam logic [29:0] ONE_Q28 = 30'd268435456;
  localparam logic [14:0] ONE15 = 15'(frn_pkg::ONE_Q14);

  function automatic logic [58:0] div1_step(logic [57:0] r, logic [29:0] dv, int b);
    logic [57:0] t;
    t = {28'b0, dv} << b;
    if (r >= t) div1_step = {1'b1, r - t};
    else div1_step = {1'b0, r};
  endfunction

  function automatic logic [61:0] fd_step(logic [60:0] r, logic [30:0] dv, int b);
    logic [60:0] t;
    t = {30'b0, dv} << b;
    if (r >= t) fd_step = {1'b1, r - t};
    else fd_step = {1'b0, r};
  endfunction

  function automatic logic [34:0] vd_step(logic [33:0] r, logic [14:0] dv, int b);
    logic [33:0] t;
    t = 34'(dv) << b;
    if (r >= t) vd_step = {1'b1, r - t};
    else vd_step = {1'b0, r};
  endfunction

  function automatic logic [43:0] sqrt_step(logic [28:0] r, logic [14:0] res, int b);
    logic [30:0] t;
    t = (31'(res) << (b + 1)) | (31'd1 << (2 * b));
    if (31'(r) >= t) sqrt_step = {29'(31'(r) - t), res | (15'd1 << b)};
    else sqrt_step = {r, res};
  endfunction

  logic                  pipe_en;
  logic [PIPE_DEPTH:1]   vld;
  logic [14:0]           env_ior;

  logic signed [31:0] s1_p [3];
  logic signed [15:0] s1_d [3];
  logic signed [15:0] s1_n [3];
  logic [14:0]        s1_sior;

  logic signed [33:0] s2c_dot, s2c_cr;
  logic signed [15:0] s2c_c;
  logic               s2c_inside;
  logic [14:0]        s2_etai, s2_etat, s2_ac;
  logic signed [16:0] s2_nn [3];
  logic signed [15:0] s2_d [3];

  logic signed [32:0] s3c_v [3];
  logic [29:0]        s3_ac2, s3_ei2, s3_et2;
  logic signed [30:0] s3_v [3];
  logic [14:0]        s3_etai, s3_etat, s3_ac;
  logic signed [16:0] s3_nn [3];

  logic [58:0]        s4_lhs;
  logic [57:0]        s4_rhs;
  logic signed [46:0] s4_w [3];
  logic [29:0]        s4_et2;
  logic [14:0]        s4_etai, s4_etat, s4_ac;
  logic signed [16:0] s4_nn [3];
  frn_pkg::side_t     s5c_side;

  logic [57:0]    d1_rem [0:D1_N];
  logic [29:0]    d1_dv  [0:D1_N];
  logic [28:0]    d1_q   [0:D1_N];
  frn_pkg::side_t d1_sd  [0:D1_N];
  logic [58:0]    d1c_st [0:D1_N-1];

  logic [28:0]    sq_rem [0:SQ_N-1];
  logic [14:0]    sq_res [0:SQ_N-1];
  frn_pkg::side_t sq_sd  [0:SQ_N-1];
  logic [43:0]    sqc_st [0:SQ_N-1];

  logic [29:0]        fa_as, fa_bs, fa_ap, fa_bp;
  logic signed [16:0] fa_nn [3];
  logic signed [46:0] fa_w [3];
  logic [14:0]        fa_etat;
  logic               fa_tir;

  logic [29:0]        fb_num_s, fb_num_p;
  logic [30:0]        fb_den_s, fb_den_p;
  logic signed [46:0] fb_ecn [3];
  logic signed [46:0] fb_w [3];
  logic [14:0]        fb_etat;
  logic               fb_tir;

  logic [60:0] fd_rem_s [0:FD_N-1];
  logic [60:0] fd_rem_p [0:FD_N-1];
  logic [30:0] fd_dv_s  [0:FD_N-1];
  logic [30:0] fd_dv_p  [0:FD_N-1];
  logic [30:0] fd_q_s   [0:FD_N-1];
  logic [30:0] fd_q_p   [0:FD_N-1];
  logic [61:0] fdc_st_s [0:FD_N-1];
  logic [61:0] fdc_st_p [0:FD_N-1];

  logic [61:0] fq_rs2, fq_rp2;
  logic [62:0] krc_sum;
  logic [15:0] krc_full;
  logic [14:0] kr_next;
  logic [14:0] o_kr;

  logic signed [47:0] vc_num [3];
  logic [14:0]        vc_etat;
  logic               vc_tir;

  logic [47:0]        vyc_mag [3];
  logic [48:0]        vyc_sum [3];
  logic [33:0]        vy_y [3];
  logic               vy_neg [3];
  logic [29:0]        vy_lim;
  logic [14:0]        vy_etat;
  logic               vy_tir;

  logic [33:0] vd_rem [0:VD_N-1][0:2];
  logic [14:0] vd_q   [0:VD_N-1][0:2];
  logic        vd_sat [0:VD_N-1][0:2];
  logic        vd_neg [0:VD_N-1][0:2];
  logic [14:0] vd_dv  [0:VD_N-1];
  logic        vd_tir [0:VD_N-1];
  logic [34:0] vdc_st [0:VD_N-1][0:2];

  frn_pkg::vec_t vfc;
  logic [14:0]   vfc_mag [3];
  frn_pkg::vec_t vdl [0:VDL_N-1];

  assign pipe_en = !vld[PIPE_DEPTH] || result.ready;
  assign ray.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      env_ior <= frn_pkg::ENV_IOR_RESET;
    end else begin
      if (pipe_en) vld <= {vld[PIPE_DEPTH-1:1], ray.valid};
      if (cfg_we) env_ior <= cfg_wdata;
    end
  end

  always_comb begin
    s2c_dot = 34'(s1_p[0]) + 34'(s1_p[1]) + 34'(s1_p[2]);
    s2c_cr = (s2c_dot + 34'sd8192) >>> 14;
    if (s2c_cr > 34'sd16384) s2c_c = 16'sd16384;
    else if (s2c_cr < -34'sd16384) s2c_c = -16'sd16384;
    else s2c_c = 16'(s2c_cr);
    s2c_inside = s2c_c > 16'sd0;
    for (int i = 0; i < 3; i++) begin
      s3c_v[i] = (33'(s2_d[i]) <<< 14) + 33'($signed({1'b0, s2_ac})) * 33'(s2_nn[i]);
    end
    s5c_side.tir = (s4_etat == 15'd0) || (s4_lhs >= 59'(s4_rhs));
    s5c_side.etai = s4_etai;
    s5c_side.etat = s4_etat;
    s5c_side.ac = s4_ac;
    for (int i = 0; i < 3; i++) begin
      s5c_side.nn[i] = s4_nn[i];
      s5c_side.w[i] = s4_w[i];
    end
    for (int k = 0; k < D1_N; k++) begin
      d1c_st[k] = div1_step(d1_rem[k], d1_dv[k], D1_N - 1 - k);
    end
    sqc_st[0] = sqrt_step(d1_q[D1_N], 15'd0, SQ_N - 1);
    for (int j = 1; j < SQ_N; j++) begin
      sqc_st[j] = sqrt_step(sq_rem[j-1], sq_res[j-1], SQ_N - 1 - j);
    end
    fdc_st_s[0] = fd_step({1'b0, fb_num_s, 30'b0}, fb_den_s, FD_N - 1);
    fdc_st_p[0] = fd_step({1'b0, fb_num_p, 30'b0}, fb_den_p, FD_N - 1);
    for (int j = 1; j < FD_N; j++) begin
      fdc_st_s[j] = fd_step(fd_rem_s[j-1], fd_dv_s[j-1], FD_N - 1 - j);
      fdc_st_p[j] = fd_step(fd_rem_p[j-1], fd_dv_p[j-1], FD_N - 1 - j);
    end
    krc_sum = 63'(fq_rs2) + 63'(fq_rp2);
    krc_full = 16'((krc_sum + (63'd1 << 46)) >> 47);
    if (vdl[VDL_N-2].tir) kr_next = ONE15;
    else if (krc_full > 16'(ONE15)) kr_next = ONE15;
    else kr_next = 15'(krc_full);
    for (int i = 0; i < 3; i++) begin
      vyc_mag[i] = vc_num[i][47] ? 48'(-vc_num[i]) : 48'(vc_num[i]);
      vyc_sum[i] = 49'(vyc_mag[i]) + 49'({vc_etat, 13'b0});
      vdc_st[0][i] = vd_step(vy_y[i], vy_etat, VD_N - 1);
    end
    for (int j = 1; j < VD_N; j++) begin
      for (int i = 0; i < 3; i++) begin
        vdc_st[j][i] = vd_step(vd_rem[j-1][i], vd_dv[j-1], VD_N - 1 - j);
      end
    end
    vfc.tir = vd_tir[VD_N-1];
    for (int i = 0; i < 3; i++) begin
      vfc_mag[i] = vd_sat[VD_N-1][i] ? ONE15 : vd_q[VD_N-1][i];
      if (vd_tir[VD_N-1]) vfc.refr[i] = 16'd0;
      else if (vd_neg[VD_N-1][i]) vfc.refr[i] = -16'(vfc_mag[i]);
      else vfc.refr[i] = 16'(vfc_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_p[0] <= 32'(ray.data.dir_x) * 32'(ray.data.norm_x);
      s1_p[1] <= 32'(ray.data.dir_y) * 32'(ray.data.norm_y);
      s1_p[2] <= 32'(ray.data.dir_z) * 32'(ray.data.norm_z);
      s1_d[0] <= ray.data.dir_x;
      s1_d[1] <= ray.data.dir_y;
      s1_d[2] <= ray.data.dir_z;
      s1_n[0] <= ray.data.norm_x;
      s1_n[1] <= ray.data.norm_y;
      s1_n[2] <= ray.data.norm_z;
      s1_sior <= ray.data.surface_ior;

      s2_etai <= s2c_inside ? s1_sior : env_ior;
      s2_etat <= s2c_inside ? env_ior : s1_sior;
      s2_ac <= (s2c_c < 16'sd0) ? 15'(-s2c_c) : 15'(s2c_c);
      for (int i = 0; i < 3; i++) begin
        s2_nn[i] <= s2c_inside ? -17'(s1_n[i]) : 17'(s1_n[i]);
        s2_d[i] <= s1_d[i];
      end

      s3_ac2 <= 30'(s2_ac) * 30'(s2_ac);
      s3_ei2 <= 30'(s2_etai) * 30'(s2_etai);
      s3_et2 <= 30'(s2_etat) * 30'(s2_etat);
      s3_etai <= s2_etai;
      s3_etat <= s2_etat;
      s3_ac <= s2_ac;
      for (int i = 0; i < 3; i++) begin
        s3_v[i] <= 31'(s3c_v[i]);
        s3_nn[i] <= s2_nn[i];
      end

      s4_lhs <= 59'(s3_ei2) * 59'(ONE_Q28 - s3_ac2);
      s4_rhs <= {s3_et2, 28'b0};
      s4_et2 <= s3_et2;
      s4_etai <= s3_etai;
      s4_etat <= s3_etat;
      s4_ac <= s3_ac;
      for (int i = 0; i < 3; i++) begin
        s4_w[i] <= 47'($signed({1'b0, s3_etai})) * 47'(s3_v[i]);
        s4_nn[i] <= s3_nn[i];
      end

      d1_rem[0] <= 58'(59'(s4_rhs) - s4_lhs);
      d1_dv[0] <= s4_et2;
      d1_q[0] <= '0;
      d1_sd[0] <= s5c_side;
      for (int k = 0; k < D1_N; k++) begin
        d1_rem[k+1] <= d1c_st[k][57:0];
        d1_q[k+1] <= d1c_st[k][58] ? (d1_q[k] | (29'd1 << (D1_N - 1 - k))) : d1_q[k];
        d1_dv[k+1] <= d1_dv[k];
        d1_sd[k+1] <= d1_sd[k];
      end

      sq_sd[0] <= d1_sd[D1_N];
      for (int j = 0; j < SQ_N; j++) begin
        sq_rem[j] <= sqc_st[j][43:15];
        sq_res[j] <= sqc_st[j][14:0];
      end
      for (int j = 1; j < SQ_N; j++) begin
        sq_sd[j] <= sq_sd[j-1];
      end

      fa_as <= 30'(sq_sd[SQ_N-1].etat) * 30'(sq_sd[SQ_N-1].ac);
      fa_bs <= 30'(sq_sd[SQ_N-1].etai) * 30'(sq_res[SQ_N-1]);
      fa_ap <= 30'(sq_sd[SQ_N-1].etai) * 30'(sq_sd[SQ_N-1].ac);
      fa_bp <= 30'(sq_sd[SQ_N-1].etat) * 30'(sq_res[SQ_N-1]);
      fa_etat <= sq_sd[SQ_N-1].etat;
      fa_tir <= sq_sd[SQ_N-1].tir;
      for (int i = 0; i < 3; i++) begin
        fa_nn[i] <= $signed(sq_sd[SQ_N-1].nn[i]);
        fa_w[i] <= $signed(sq_sd[SQ_N-1].w[i]);
      end

      if (fa_as == 30'd0 && fa_bs == 30'd0) begin
        fb_num_s <= 30'd1;
        fb_den_s <= 31'd1;
      end else begin
        fb_num_s <= (fa_as > fa_bs) ? fa_as - fa_bs : fa_bs - fa_as;
        fb_den_s <= 31'(fa_as) + 31'(fa_bs);
      end
      if (fa_ap == 30'd0 && fa_bp == 30'd0) begin
        fb_num_p <= 30'd1;
        fb_den_p <= 31'd1;
      end else begin
        fb_num_p <= (fa_ap > fa_bp) ? fa_ap - fa_bp : fa_bp - fa_ap;
        fb_den_p <= 31'(fa_ap) + 31'(fa_bp);
      end
      fb_etat <= fa_etat;
      fb_tir <= fa_tir;
      for (int i = 0; i < 3; i++) begin
        fb_ecn[i] <= 47'($signed({1'b0, fa_bp})) * 47'(fa_nn[i]);
        fb_w[i] <= fa_w[i];
      end

      fd_dv_s[0] <= fb_den_s;
      fd_dv_p[0] <= fb_den_p;
      fd_q_s[0] <= fdc_st_s[0][61] ? (31'd1 << (FD_N - 1)) : 31'd0;
      fd_q_p[0] <= fdc_st_p[0][61] ? (31'd1 << (FD_N - 1)) : 31'd0;
      for (int j = 0; j < FD_N; j++) begin
        fd_rem_s[j] <= fdc_st_s[j][60:0];
        fd_rem_p[j] <= fdc_st_p[j][60:0];
      end
      for (int j = 1; j < FD_N; j++) begin
        fd_dv_s[j] <= fd_dv_s[j-1];
        fd_dv_p[j] <= fd_dv_p[j-1];
        fd_q_s[j] <= fdc_st_s[j][61] ? (fd_q_s[j-1] | (31'd1 << (FD_N - 1 - j)))
                                     : fd_q_s[j-1];
        fd_q_p[j] <= fdc_st_p[j][61] ? (fd_q_p[j-1] | (31'd1 << (FD_N - 1 - j)))
                                     : fd_q_p[j-1];
      end

      fq_rs2 <= 62'(fd_q_s[FD_N-1]) * 62'(fd_q_s[FD_N-1]);
      fq_rp2 <= 62'(fd_q_p[FD_N-1]) * 62'(fd_q_p[FD_N-1]);
      o_kr <= kr_next;

      vc_etat <= fb_etat;
      vc_tir <= fb_tir;
      for (int i = 0; i < 3; i++) begin
        vc_num[i] <= 48'(fb_w[i]) - 48'(fb_ecn[i]);
      end

      vy_lim <= 30'(vc_etat) * 30'd16385;
      vy_etat <= vc_etat;
      vy_tir <= vc_tir;
      for (int i = 0; i < 3; i++) begin
        vy_neg[i] <= vc_num[i][47];
        vy_y[i] <= 34'(vyc_sum[i] >> 14);
      end

      vd_dv[0] <= vy_etat;
      vd_tir[0] <= vy_tir;
      for (int i = 0; i < 3; i++) begin
        vd_sat[0][i] <= vy_y[i] >= 34'(vy_lim);
        vd_neg[0][i] <= vy_neg[i];
        vd_q[0][i] <= vdc_st[0][i][34] ? (15'd1 << (VD_N - 1)) : 15'd0;
      end
      for (int j = 0; j < VD_N; j++) begin
        for (int i = 0; i < 3; i++) begin
          vd_rem[j][i] <= vdc_st[j][i][33:0];
        end
      end
      for (int j = 1; j < VD_N; j++) begin
        vd_dv[j] <= vd_dv[j-1];
        vd_tir[j] <= vd_tir[j-1];
        for (int i = 0; i < 3; i++) begin
          vd_sat[j][i] <= vd_sat[j-1][i];
          vd_neg[j][i] <= vd_neg[j-1][i];
          vd_q[j][i] <= vdc_st[j][i][34] ? (vd_q[j-1][i] | (15'd1 << (VD_N - 1 - j)))
                                         : vd_q[j-1][i];
        end
      end

      vdl[0] <= vfc;
      for (int k = 1; k < VDL_N; k++) begin
        vdl[k] <= vdl[k-1];
      end
    end
  end

  assign result.valid = vld[PIPE_DEPTH];
  assign result.data.reflectance = o_kr;
  assign result.data.refr_x = $signed(vdl[VDL_N-1].refr[0]);
  assign result.data.refr_y = $signed(vdl[VDL_N-1].refr[1]);
  assign result.data.refr_z = $signed(vdl[VDL_N-1].refr[2]);
  assign result.data.total_reflect = vdl[VDL_N-1].tir;

  a_tir_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.total_reflect |->
      result.data.reflectance == ONE15 && result.data.refr_x == 16'sd0 &&
      result.data.refr_y == 16'sd0 && result.data.refr_z == 16'sd0)
    else $error("total reflection beat without unit reflectance and zero vector");

  a_kr_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.reflectance <= ONE15)
    else $error("reflectance above one");

  a_vec_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      result.data.refr_x <= 16'sd16384 && result.data.refr_x >= -16'sd16384 &&
      result.data.refr_y <= 16'sd16384 && result.data.refr_y >= -16'sd16384 &&
      result.data.refr_z <= 16'sd16384 && result.data.refr_z >= -16'sd16384)
    else $error("refraction component outside saturation range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

endmodule

FILE: tb/sv/tb_fresnel_refraction_unit.sv
// Testbench for fresnel_refraction_unit: drives ray beats, predicts reflectance
// and refraction vectors in fixed point, and checks every result beat in order.
// Depends on frn_pkg, frn_chan_if and the RTL top level.
`timescale 1ns / 1ps
module tb_fresnel_refraction_unit;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;

  frn_chan_if #(.T(frn_pkg::frn_in_t)) ray ();
  frn_chan_if #(.T(frn_pkg::frn_out_t)) result ();

  fresnel_refraction_unit dut (
    .clk(clk), .rst(rst), .ray(ray.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  frn_pkg::frn_in_t rays_pending[$];
  frn_pkg::frn_out_t shading_expected[$];
  logic [14:0] medium_ior = frn_pkg::ENV_IOR_RESET;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit ray_stalled = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] fres_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] den, num;
    den = a + b;
    num = (a > b) ? a - b : b - a;
    if (den == 0) return 64'd1 << 30;
    return (num << 30) / den;
  endfunction

  function automatic frn_pkg::frn_out_t shade_hit(frn_pkg::frn_in_t h, logic [14:0] env);
    frn_pkg::frn_out_t o;
    longint d[3], n[3];
    longint dotp, c, nn, num, den, q;
    logic [63:0] etai, etat, ac, s2, lhs, rhs, cost, rs, rp, sum, kr, mag;
    bit leaving;
    d[0] = h.dir_x; d[1] = h.dir_y; d[2] = h.dir_z;
    n[0] = h.norm_x; n[1] = h.norm_y; n[2] = h.norm_z;
    dotp = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    c = (dotp + 8192) >>> 14;
    if (c > frn_pkg::ONE_Q14) c = frn_pkg::ONE_Q14;
    if (c < -frn_pkg::ONE_Q14) c = -frn_pkg::ONE_Q14;
    leaving = c > 0;
    etai = leaving ? 64'(h.surface_ior) : 64'(env);
    etat = leaving ? 64'(env) : 64'(h.surface_ior);
    ac = (c < 0) ? -c : c;
    s2 = (64'd1 << 28) - ac * ac;
    lhs = etai * etai * s2;
    rhs = (etat * etat) << 28;
    o = '0;
    if (etat == 0 || lhs >= rhs) begin
      o.reflectance = 15'(frn_pkg::ONE_Q14);
      o.total_reflect = 1'b1;
      return o;
    end
    cost = isqrt((rhs - lhs) / (etat * etat));
    rs = fres_ratio(etat * ac, etai * cost);
    rp = fres_ratio(etai * ac, etat * cost);
    sum = rs * rs + rp * rp;
    kr = (sum + (64'd1 << 46)) >> 47;
    if (kr > frn_pkg::ONE_Q14) kr = frn_pkg::ONE_Q14;
    o.reflectance = kr[14:0];
    for (int i = 0; i < 3; i++) begin
      nn = leaving ? -n[i] : n[i];
      num = longint'(etai) * (d[i] * frn_pkg::ONE_Q14 + longint'(ac) * nn)
          - longint'(etat) * longint'(cost) * nn;
      den = longint'(etat) * frn_pkg::ONE_Q14;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      if (q > frn_pkg::ONE_Q14) q = frn_pkg::ONE_Q14;
      if (q < -frn_pkg::ONE_Q14) q = -frn_pkg::ONE_Q14;
      if (i == 0) o.refr_x = q[15:0];
      else if (i == 1) o.refr_y = q[15:0];
      else o.refr_z = q[15:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Random hit: unit-ish direction and normal triples with a full-range spread, or all fields random when noise is set.
  function automatic frn_pkg::frn_in_t random_hit(bit noise);
    frn_pkg::frn_in_t h;
    int a, b;
    if (noise) begin
      h.dir_x = 16'($urandom);
      h.dir_y = 16'($urandom);
      h.dir_z = 16'($urandom);
      h.norm_x = 16'($urandom);
      h.norm_y = 16'($urandom);
      h.norm_z = 16'($urandom);
      h.surface_ior = 15'($urandom);
      return h;
    end
    a = $urandom_range(0, 16384);
    b = $urandom_range(0, 16384 - a);
    h.dir_x = 16'($urandom_range(0, 1) ? -a : a);
    h.dir_y = 16'($urandom_range(0, 1) ? -b : b);
    h.dir_z = 16'($urandom_range(0, 1) ? -(16384 - a - b) : (16384 - a - b));
    a = $urandom_range(0, 16384);
    b = $urandom_range(0, 16384 - a);
    h.norm_x = 16'($urandom_range(0, 1) ? -b : b);
    h.norm_y = 16'($urandom_range(0, 1) ? -(16384 - a - b) : (16384 - a - b));
    h.norm_z = 16'($urandom_range(0, 1) ? -a : a);
    case ($urandom_range(0, 3))
      0: h.surface_ior = 15'($urandom_range(8192, 32767));
      1: h.surface_ior = 15'($urandom_range(8192, 14000));
      2: h.surface_ior = 15'($urandom_range(0, 32767));
      default: h.surface_ior = ($urandom_range(0, 1) == 0) ? 15'd8192 : 15'd32767;
    endcase
    return h;
  endfunction

  function automatic frn_pkg::frn_in_t make_hit(int dx, int dy, int dz, int nx, int ny,
                                                int nz, int ior);
    frn_pkg::frn_in_t h;
    h.dir_x = 16'(dx); h.dir_y = 16'(dy); h.dir_z = 16'(dz);
    h.norm_x = 16'(nx); h.norm_y = 16'(ny); h.norm_z = 16'(nz);
    h.surface_ior = 15'(ior);
    return h;
  endfunction

  // Driver.
  always @(negedge clk) begin
    if (rst) begin
      ray.valid <= 1'b0;
      ray.data <= '0;
    end else if (ray_stalled) begin
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      ray.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      src_gap <= $urandom_range(0, 9);
      ray.valid <= 1'b0;
    end else if (rays_pending.size() > 0) begin
      ray.valid <= 1'b1;
      ray.data <= rays_pending.pop_front();
    end else begin
      ray.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      result.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      snk_gap <= $urandom_range(0, 9);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    frn_pkg::frn_out_t want;
    cycles <= cycles + 1;
    ray_stalled <= !rst && ray.valid && !ray.ready;
    if (!rst && ray.valid && ray.ready)
      shading_expected.push_back(shade_hit(ray.data, medium_ior));
    if (!rst && result.valid && result.ready) begin
      if (shading_expected.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = shading_expected.pop_front();
        if (result.data.reflectance !== want.reflectance)
          report_mismatch("reflectance", result.data.reflectance, want.reflectance);
        if (result.data.refr_x !== want.refr_x)
          report_mismatch("refr_x", result.data.refr_x, want.refr_x);
        if (result.data.refr_y !== want.refr_y)
          report_mismatch("refr_y", result.data.refr_y, want.refr_y);
        if (result.data.refr_z !== want.refr_z)
          report_mismatch("refr_z", result.data.refr_z, want.refr_z);
        if (result.data.total_reflect !== want.total_reflect)
          report_mismatch("total_reflect", result.data.total_reflect, want.total_reflect);
      end
    end
    if (cycles > 400000) begin
      $display("fresnel_refraction_unit test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (rays_pending.size() > 0 || ray.valid || shading_expected.size() > 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_medium(logic [14:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    medium_ior <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [14:0] settings[5];
    settings = '{15'd8192, 15'd32767, 15'd10895, 15'd0, 15'($urandom_range(8192, 32767))};
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    rays_pending.push_back(make_hit(0, 0, -16384, 0, 0, 16384, 12288));
    rays_pending.push_back(make_hit(0, 0, 16384, 0, 0, 16384, 12288));
    rays_pending.push_back(make_hit(16384, 0, 0, 0, 0, 16384, 12288));
    rays_pending.push_back(make_hit(11585, 0, 11585, 0, 0, 16384, 12288));
    rays_pending.push_back(make_hit(-16384, -16384, -16384, 16384, 16384, 16384, 32767));
    rays_pending.push_back(make_hit(-32768, 32767, -32768, 32767, -32768, 32767, 0));
    rays_pending.push_back(make_hit(0, 0, 0, 0, 0, 0, 8192));
    rays_pending.push_back(make_hit(0, 0, -16384, 0, 0, 16384, 0));
    rays_pending.push_back(make_hit(0, 0, 16384, 0, 0, 16384, 8192));
    rays_pending.push_back(make_hit(-1, 1, -1, 1, -1, 1, 32767));
    rays_pending.push_back(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 16384));
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      set_medium(settings[ph]);
      if (ph == 4) calm = 1'b1;
      for (int k = 0; k < 240; k++)
        rays_pending.push_back(random_hit($urandom_range(0, 9) == 0));
    end
    wait_drained();
    if (errors == 0) begin
      $display("fresnel_refraction_unit test passed");
    end else begin
      $display("fresnel_refraction_unit test failed");
    end
    $finish;
  end
endmodule
